// File: design/rvtrap_pkg.sv
// Package for the RISC-V trap unit: request/response payloads, CSR block,
// architectural state, operation codes and register indexes. No dependencies.
`timescale 1ns / 1ps

package rvtrap_pkg;

   localparam int unsigned XLEN      = 32;
   localparam int unsigned CAUSE_W   = 5;
   localparam int unsigned OP_W      = 3;
   localparam int unsigned PRIV_W    = 2;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [OP_W-1:0] OP_RAISE_INT = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR_PEND = 3'd1;
   localparam logic [OP_W-1:0] OP_TAKE_INT  = 3'd2;
   localparam logic [OP_W-1:0] OP_EXCEPTION = 3'd3;
   localparam logic [OP_W-1:0] OP_MRET      = 3'd4;
   localparam logic [OP_W-1:0] OP_SRET      = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_MIDELEG = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEDELEG = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MTVEC   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STVEC   = 3'd5;

   localparam logic [PRIV_W-1:0] PRIV_USER    = 2'd0;
   localparam logic [PRIV_W-1:0] PRIV_SUPER   = 2'd1;
   localparam logic [PRIV_W-1:0] PRIV_MACHINE = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [CAUSE_W-1:0] cause;
      logic [XLEN-1:0]    fault_value;
      logic [XLEN-1:0]    current_pc;
      logic               waiting;
      logic [XLEN-1:0]    resume_pc;
   } req_type;

   typedef struct packed {
      logic              redirect;
      logic [XLEN-1:0]   target_pc;
      logic [PRIV_W-1:0] privilege;
      logic              left_wait;
      logic [XLEN-1:0]   machine_pending;
      logic [XLEN-1:0]   super_pending;
   } rsp_type;

   typedef struct packed {
      logic [XLEN-1:0] int_deleg;
      logic [XLEN-1:0] exc_deleg;
      logic [XLEN-1:0] mach_int_en;
      logic [XLEN-1:0] super_int_en;
      logic [XLEN-1:0] mach_vector;
      logic [XLEN-1:0] super_vector;
   } cfg_type;

   // Only the status bits that the trap flow touches are kept.
   typedef struct packed {
      logic [PRIV_W-1:0] priv;
      logic              mie;
      logic              mpie;
      logic [PRIV_W-1:0] mpp;
      logic              sie;
      logic              spie;
      logic              spp;
      logic [XLEN-1:0]   mach_pend;
      logic [XLEN-1:0]   super_pend;
      logic [XLEN-1:0]   mach_epc;
      logic [XLEN-1:0]   super_epc;
   } state_type;

   localparam state_type STATE_RESET = {PRIV_MACHINE, {($bits(state_type) - PRIV_W){1'b0}}};

   function automatic logic [CAUSE_W-1:0] lowest_set(input logic [XLEN-1:0] v);
      logic [CAUSE_W-1:0] idx;
      idx = '0;
      for (int i = XLEN - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = i[CAUSE_W-1:0];
         end
      end
      return idx;
   endfunction

   function automatic logic [XLEN-1:0] vector_target(input logic [XLEN-1:0] vec,
                                                     input logic [CAUSE_W-1:0] cause,
                                                     input logic is_int);
      logic [XLEN-1:0] base;
      base = {vec[XLEN-1:2], 2'b00};
      if (is_int && vec[0]) begin
         base = base + {{(XLEN-CAUSE_W-2){1'b0}}, cause, 2'b00};
      end
      return base;
   endfunction

endpackage

// File: design/rvtrap_csr.sv
// Configuration registers of the trap unit: delegation, enables, vectors.
// Depends on rvtrap_pkg.
`timescale 1ns / 1ps

module rvtrap_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rvtrap_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rvtrap_pkg::XLEN-1:0]     csr_data,
   output rvtrap_pkg::cfg_type             cfg
);
   import rvtrap_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MIDELEG: cfg_in.int_deleg    = csr_data;
            CSR_MEDELEG: cfg_in.exc_deleg    = csr_data;
            CSR_MIE:     cfg_in.mach_int_en  = csr_data;
            CSR_SIE:     cfg_in.super_int_en = csr_data;
            CSR_MTVEC:   cfg_in.mach_vector  = csr_data;
            CSR_STVEC:   cfg_in.super_vector = csr_data;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/rvtrap_exec.sv
// Trap datapath: decodes one request against the current state and CSRs,
// producing the response and the next architectural state. Depends on rvtrap_pkg.
`timescale 1ns / 1ps

module rvtrap_exec (
   input  rvtrap_pkg::req_type   req,
   input  rvtrap_pkg::cfg_type   cfg,
   input  rvtrap_pkg::state_type cur,
   output rvtrap_pkg::state_type nxt,
   output rvtrap_pkg::rsp_type   rsp
);
   import rvtrap_pkg::*;

   logic [XLEN-1:0]    bit_mask;
   logic [XLEN-1:0]    epc;
   logic [CAUSE_W-1:0] int_cause;
   logic               int_to_super;
   logic               take_super;
   logic               take_mach;
   logic               do_trap;
   logic               trap_super;
   logic               trap_is_int;
   logic [CAUSE_W-1:0] trap_cause;
   logic [XLEN-1:0]    target;

   assign bit_mask  = {{(XLEN-1){1'b0}}, 1'b1} << req.cause;
   assign epc       = req.waiting ? req.resume_pc : req.current_pc;
   assign int_cause = lowest_set(cur.super_pend);
   assign int_to_super = cfg.int_deleg[int_cause];

   assign take_super = !(!cur.sie && (cur.priv != PRIV_USER) && !req.waiting)
                       && cfg.super_int_en[int_cause];
   assign take_mach  = !(!cur.mie && (cur.priv == PRIV_MACHINE) && !req.waiting)
                       && cfg.mach_int_en[int_cause];

   always_comb begin
      do_trap     = 1'b0;
      trap_super  = 1'b0;
      trap_is_int = 1'b0;
      trap_cause  = req.cause;
      case (req.operation)
         OP_TAKE_INT: begin
            trap_is_int = 1'b1;
            trap_cause  = int_cause;
            trap_super  = int_to_super;
            do_trap     = (int_cause != '0) && (int_to_super ? take_super : take_mach);
         end
         OP_EXCEPTION: begin
            do_trap    = 1'b1;
            trap_super = |(bit_mask & cfg.exc_deleg);
         end
         default: begin
            do_trap = 1'b0;
         end
      endcase
   end

   assign target = vector_target(trap_super ? cfg.super_vector : cfg.mach_vector,
                                 trap_cause, trap_is_int);

   always_comb begin
      nxt           = cur;
      rsp.redirect  = 1'b0;
      rsp.target_pc = '0;
      rsp.left_wait = 1'b0;
      case (req.operation)
         OP_RAISE_INT: begin
            if (|(bit_mask & cfg.int_deleg)) begin
               nxt.super_pend = cur.super_pend | bit_mask;
            end else begin
               nxt.mach_pend = cur.mach_pend | bit_mask;
            end
         end
         OP_CLEAR_PEND: begin
            nxt.super_pend = cur.super_pend & ~bit_mask;
            nxt.mach_pend  = cur.mach_pend & ~bit_mask;
         end
         OP_TAKE_INT, OP_EXCEPTION: begin
            if (do_trap) begin
               rsp.redirect  = 1'b1;
               rsp.target_pc = target;
               rsp.left_wait = req.waiting;
               if (trap_super) begin
                  nxt.spie      = 1'b1;
                  nxt.sie       = 1'b0;
                  nxt.super_epc = epc;
                  nxt.spp       = (cur.priv != PRIV_USER);
                  nxt.priv      = PRIV_SUPER;
               end else begin
                  nxt.mpie     = 1'b1;
                  nxt.mie      = 1'b0;
                  nxt.mach_epc = epc;
                  nxt.mpp      = cur.priv;
                  nxt.priv     = PRIV_MACHINE;
               end
            end
         end
         OP_MRET: begin
            nxt.priv      = cur.mpp;
            nxt.mpp       = PRIV_USER;
            nxt.mie       = cur.mpie;
            nxt.mpie      = 1'b1;
            rsp.redirect  = 1'b1;
            rsp.target_pc = cur.mach_epc;
         end
         OP_SRET: begin
            nxt.priv      = {1'b0, cur.spp};
            nxt.spp       = 1'b0;
            nxt.sie       = cur.spie;
            nxt.spie      = 1'b1;
            rsp.redirect  = 1'b1;
            rsp.target_pc = cur.super_epc;
         end
         default: begin
            nxt = cur;
         end
      endcase
      rsp.privilege       = nxt.priv;
      rsp.machine_pending = nxt.mach_pend;
      rsp.super_pending   = nxt.super_pend;
   end

endmodule

// File: design/riscv_trap_unit.sv
// Top level of the RISC-V machine/supervisor trap unit: request register,
// state registers and response register. Depends on rvtrap_pkg, rvtrap_csr, rvtrap_exec.
`timescale 1ns / 1ps

// Usage:
//   req_*  : one trap-unit request per handshake (raise/clear/take interrupt,
//            exception, mret, sret). Accepted when req_valid and req_ready.
//   rsp_*  : exactly one response per request, in request order.
//   csr_*  : CSR writes (delegation, enables, vectors); always ready. Write
//            only while no request is in flight.
//   Path: an accepted request is held in the request stage, then its response
//   is loaded into the response stage (two registers) and shown on rsp_*.
//   Throughput: one request per cycle when not stalled. The trap state is updated
//   in the same edge that loads the response register, so the next request sees it.
//   Stall: while rsp_ready is low the response holds; the request stage keeps
//   one more request and req_ready drops when both stages are full.
//   Reset: synchronous; clears CSRs, pending words, status and epc, sets the
//   privilege to machine mode and empties both stages.

module riscv_trap_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rvtrap_pkg::req_type              req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rvtrap_pkg::rsp_type              rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rvtrap_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rvtrap_pkg::XLEN-1:0]      csr_data
);
   import rvtrap_pkg::*;

   cfg_type   cfg;
   logic      stage_valid_ff;
   req_type   stage_req_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   state_type state_ff;
   state_type state_in;
   logic      advance;

   rvtrap_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rvtrap_exec u_exec (
      .req (stage_req_ff),
      .cfg (cfg),
      .cur (state_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   assign advance     = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !stage_valid_ff || advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= STATE_RESET;
      end else begin
         if (req_valid && req_ready) begin
            stage_valid_ff <= 1'b1;
         end else if (advance) begin
            stage_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: tb/tb_riscv_trap_unit.sv
// Self-checking testbench for riscv_trap_unit: directed and random trap requests
// checked against an in-bench trap-state predictor. Depends on rvtrap_pkg, riscv_trap_unit.
`timescale 1ns / 1ps

module tb_riscv_trap_unit;
   import rvtrap_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam int WORD_ZERO = 0;
   localparam int WORD_ONES = 1;
   localparam int WORD_RAND = 2;

   class trap_scoreboard;
      state_type hart;
      cfg_type   csr;
      rsp_type   awaited_rsp [$];
      int        errors;

      function new();
         hart = '0;
         hart.priv = PRIV_MACHINE;
         csr = '0;
         errors = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [XLEN-1:0] data);
         case (idx)
            CSR_MIDELEG: csr.int_deleg = data;
            CSR_MEDELEG: csr.exc_deleg = data;
            CSR_MIE:     csr.mach_int_en = data;
            CSR_SIE:     csr.super_int_en = data;
            CSR_MTVEC:   csr.mach_vector = data;
            CSR_STVEC:   csr.super_vector = data;
            default: ;
         endcase
      endfunction

      function logic [XLEN-1:0] enter_trap(bit to_super, logic [CAUSE_W-1:0] cause,
                                           bit is_int, logic [XLEN-1:0] epc);
         logic [XLEN-1:0] vec;
         logic [XLEN-1:0] base;
         if (to_super) begin
            hart.spie = 1'b1;
            hart.sie = 1'b0;
            hart.super_epc = epc;
            hart.spp = (hart.priv != PRIV_USER);
            hart.priv = PRIV_SUPER;
            vec = csr.super_vector;
         end else begin
            hart.mpie = 1'b1;
            hart.mie = 1'b0;
            hart.mach_epc = epc;
            hart.mpp = hart.priv;
            hart.priv = PRIV_MACHINE;
            vec = csr.mach_vector;
         end
         base = vec & ~32'h3;
         if (is_int && vec[0]) base = base + 32'(cause) * 32'd4;
         return base;
      endfunction

      function void note_request(req_type r);
         logic [XLEN-1:0]    mask;
         logic [XLEN-1:0]    epc;
         logic [CAUSE_W-1:0] lowest;
         bit                 found;
         bit                 take;
         rsp_type            e;
         mask = 32'd1 << r.cause;
         epc = r.waiting ? r.resume_pc : r.current_pc;
         found = 1'b0;
         lowest = '0;
         e = '0;
         case (r.operation)
            OP_RAISE_INT: begin
               if ((mask & csr.int_deleg) != 0) hart.super_pend |= mask;
               else hart.mach_pend |= mask;
            end
            OP_CLEAR_PEND: begin
               hart.super_pend &= ~mask;
               hart.mach_pend &= ~mask;
            end
            OP_TAKE_INT: begin
               for (int i = 0; i < XLEN; i++) begin
                  if (hart.super_pend[i] && !found) begin
                     lowest = i[CAUSE_W-1:0];
                     found = 1'b1;
                  end
               end
               if (found && lowest != 0) begin
                  if (csr.int_deleg[lowest])
                     take = !(!hart.sie && hart.priv != PRIV_USER && !r.waiting)
                            && csr.super_int_en[lowest];
                  else
                     take = !(!hart.mie && hart.priv == PRIV_MACHINE && !r.waiting)
                            && csr.mach_int_en[lowest];
                  if (take) begin
                     e.target_pc = enter_trap(csr.int_deleg[lowest], lowest, 1'b1, epc);
                     e.redirect = 1'b1;
                     e.left_wait = r.waiting;
                  end
               end
            end
            OP_EXCEPTION: begin
               e.target_pc = enter_trap(csr.exc_deleg[r.cause], r.cause, 1'b0, epc);
               e.redirect = 1'b1;
               e.left_wait = r.waiting;
            end
            OP_MRET: begin
               hart.priv = hart.mpp;
               hart.mpp = PRIV_USER;
               hart.mie = hart.mpie;
               hart.mpie = 1'b1;
               e.target_pc = hart.mach_epc;
               e.redirect = 1'b1;
            end
            OP_SRET: begin
               hart.priv = {1'b0, hart.spp};
               hart.spp = 1'b0;
               hart.sie = hart.spie;
               hart.spie = 1'b1;
               e.target_pc = hart.super_epc;
               e.redirect = 1'b1;
            end
            default: ;
         endcase
         e.privilege = hart.priv;
         e.machine_pending = hart.mach_pend;
         e.super_pending = hart.super_pend;
         awaited_rsp.push_back(e);
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("mismatch: %s", msg);
      endfunction

      function void compare_field(string name, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
         if (want !== got) flag($sformatf("%s expected %h actual %h", name, want, got));
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (awaited_rsp.size() == 0) begin
            flag($sformatf("response with no request outstanding, target %h", a.target_pc));
         end else begin
            e = awaited_rsp.pop_front();
            compare_field("redirect", 32'(e.redirect), 32'(a.redirect));
            compare_field("target_pc", e.target_pc, a.target_pc);
            compare_field("privilege", 32'(e.privilege), 32'(a.privilege));
            compare_field("left_wait", 32'(e.left_wait), 32'(a.left_wait));
            compare_field("machine_pending", e.machine_pending, a.machine_pending);
            compare_field("super_pending", e.super_pending, a.super_pending);
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [XLEN-1:0]      csr_data = '0;

   trap_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_trigger = 0;
   int hold_served = 0;
   int hold_left = 0;

   riscv_trap_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_trigger != hold_served) begin
         hold_served <= hold_trigger;
         hold_left <= 200;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_register(csr_index, csr_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_payload);
         if (req_valid && req_ready) sb.note_request(req_payload);
      end
   end

   function automatic logic [XLEN-1:0] rand_word(int mode);
      case (mode)
         WORD_ZERO: return '0;
         WORD_ONES: return '1;
         default:   return $urandom;
      endcase
   endfunction

   function automatic logic [XLEN-1:0] field_word();
      return rand_word(($urandom_range(9) < 8) ? WORD_RAND : $urandom_range(1));
   endfunction

   function automatic req_type make_req(logic [OP_W-1:0] op, logic [CAUSE_W-1:0] cause,
                                        logic [XLEN-1:0] fval, logic [XLEN-1:0] pc,
                                        logic waiting, logic [XLEN-1:0] rpc);
      req_type r;
      r.operation = op;
      r.cause = cause;
      r.fault_value = fval;
      r.current_pc = pc;
      r.waiting = waiting;
      r.resume_pc = rpc;
      return r;
   endfunction

   function automatic req_type random_req(logic [OP_W-1:0] op);
      return make_req(op, CAUSE_W'($urandom_range(31)), field_word(), field_word(),
                      1'($urandom_range(1)), field_word());
   endfunction

   function automatic logic [OP_W-1:0] pick_op();
      int roll;
      roll = $urandom_range(99);
      if (roll < 22) return OP_RAISE_INT;
      if (roll < 32) return OP_CLEAR_PEND;
      if (roll < 55) return OP_TAKE_INT;
      if (roll < 70) return OP_EXCEPTION;
      if (roll < 82) return OP_MRET;
      if (roll < 95) return OP_SRET;
      return $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
   endfunction

   task automatic send_request(input req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_csrs(input logic [XLEN-1:0] ideleg, edeleg, mien, sien,
                               mvec, svec);
      logic [CSR_IDX_W-1:0] idx [6];
      logic [XLEN-1:0]      val [6];
      idx = '{CSR_MIDELEG, CSR_MEDELEG, CSR_MIE, CSR_SIE, CSR_MTVEC, CSR_STVEC};
      val = '{ideleg, edeleg, mien, sien, mvec, svec};
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int idle, input int stall,
                            input int deleg_mode, input int en_mode, input int vec_mode,
                            input bit long_hold);
      int sent;
      sent = 0;
      drain_responses();
      program_csrs(rand_word(deleg_mode), rand_word(deleg_mode), rand_word(en_mode),
                   rand_word(en_mode), rand_word(vec_mode), rand_word(vec_mode));
      send_idle_pct = idle;
      recv_stall_pct = stall;
      while (sent < count) begin
         if (long_hold && sent >= 40 && hold_trigger == hold_served && hold_left == 0
             && hold_trigger == 0)
            hold_trigger++;
         case ($urandom_range(9))
            0, 1, 2: begin
               send_request(random_req(OP_RAISE_INT));
               send_request(random_req(OP_TAKE_INT));
               send_request(random_req($urandom_range(1) ? OP_MRET : OP_SRET));
               sent += 3;
            end
            3, 4: begin
               send_request(random_req(OP_EXCEPTION));
               send_request(random_req($urandom_range(1) ? OP_MRET : OP_SRET));
               sent += 2;
            end
            default: begin
               send_request(random_req(pick_op()));
               sent++;
            end
         endcase
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      program_csrs(32'h5555_5555, 32'h0000_ff00, '1, '1, 32'h8000_0001, 32'h4000_0102);
      send_request(make_req(OP_TAKE_INT, 5'd0, '0, '0, 1'b0, '0));
      send_request(make_req(OP_MRET, 5'd0, '0, '0, 1'b0, '0));
      send_request(make_req(OP_RAISE_INT, 5'd0, '0, '0, 1'b0, '0));
      send_request(make_req(OP_TAKE_INT, 5'd0, '0, 32'h0000_1000, 1'b0, '0));
      send_request(make_req(OP_RAISE_INT, 5'd2, '0, '0, 1'b0, '0));
      send_request(make_req(OP_TAKE_INT, 5'd31, '0, 32'h0000_2000, 1'b1, '1));
      send_request(make_req(OP_RAISE_INT, 5'd31, '1, '1, 1'b1, '1));
      send_request(make_req(OP_RAISE_INT, 5'd30, '0, '0, 1'b0, '0));
      send_request(make_req(OP_CLEAR_PEND, 5'd0, '0, '0, 1'b0, '0));
      send_request(make_req(OP_TAKE_INT, 5'd0, '0, 32'h0000_3000, 1'b0, '0));
      send_request(make_req(OP_SRET, 5'd0, '0, '0, 1'b0, '0));
      send_request(make_req(OP_TAKE_INT, 5'd0, '0, 32'h0000_3004, 1'b0, '0));
      send_request(make_req(OP_EXCEPTION, 5'd9, '1, '1, 1'b0, '0));
      send_request(make_req(OP_EXCEPTION, 5'd3, '0, '0, 1'b1, 32'hffff_fffc));
      send_request(make_req(OP_MRET, 5'd31, '1, '1, 1'b1, '1));
      send_request(make_req(OP_EXCEPTION, 5'd31, '0, '0, 1'b0, '0));
      send_request(make_req(OP_MRET, 5'd0, '0, '0, 1'b0, '0));
      send_request(make_req(OP_SRET, 5'd0, '0, '0, 1'b0, '0));
      send_request(make_req(OP_SPARE_LO, 5'd4, '1, '1, 1'b1, '1));
      send_request(make_req(OP_SPARE_HI, 5'd4, '0, '0, 1'b0, '0));
      send_request(make_req(OP_CLEAR_PEND, 5'd31, '0, '0, 1'b0, '0));
      send_request(make_req(OP_CLEAR_PEND, 5'd30, '1, '1, 1'b1, '1));
      run_phase(160, 0, 0, WORD_RAND, WORD_RAND, WORD_RAND, 1'b1);
      run_phase(160, 59, 0, WORD_ONES, WORD_ONES, WORD_ONES, 1'b0);
      run_phase(160, 0, 59, WORD_ZERO, WORD_ONES, WORD_RAND, 1'b0);
      run_phase(160, 32, 32, WORD_RAND, WORD_RAND, WORD_RAND, 1'b0);
      run_phase(160, 0, 0, WORD_RAND, WORD_ZERO, WORD_ZERO, 1'b0);
      drain_responses();
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: sim.f
design/rvtrap_pkg.sv
design/rvtrap_csr.sv
design/rvtrap_exec.sv
design/riscv_trap_unit.sv
tb/tb_riscv_trap_unit.sv
